### design/lru_key_value_cache_top_defines.svh
// Assertion macros for the LRU key-value cache checker.
// Needs signals named clock and reset in the scope of use.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// same-cycle implication
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lkv_pkg.sv
// Shared constants for the LRU key-value cache.
// No dependencies.
package lkv_pkg;

   localparam int       OP_BITS   = 1;
   localparam logic     OP_GET    = 1'b0;
   localparam logic     OP_PUT    = 1'b1;

   localparam int       CAP_BITS  = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

### design/lkv_channels.sv
// Request and response channel interfaces for the LRU key-value cache.
// Depends on lkv_pkg.
interface lkv_req_if #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic [lkv_pkg::OP_BITS-1:0]  operation;
   logic [KEY_BITS-1:0]          key;
   logic [VALUE_BITS-1:0]        value;

   modport source (output valid, operation, key, value, input ready);
   modport sink   (input valid, operation, key, value, output ready);
endinterface

interface lkv_rsp_if #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
);
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic [VALUE_BITS-1:0]   read_value;
   logic                    evicted;
   logic [KEY_BITS-1:0]     evicted_key;

   modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### design/lkv_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### design/lru_key_value_cache_top.sv
// LRU key-value cache, fully associative, N = MAX_ENTRIES entries.
// A new request is not accepted until the previous item's response has been registered;
// the key/rank RAM read port is walked one entry per cycle in a search pass and,
// for hits and inserts, again in a recency pass.
// Reset (sync, active high) empties the store and sets capacity to 16;
// a capacity write empties the store too.
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lkv_pkg::CAP_BITS-1:0]  csr_wdata,
   lkv_req_if.sink                       req_bus,
   lkv_rsp_if.source                     rsp_bus
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = (CW > lkv_pkg::CAP_BITS) ? CW : lkv_pkg::CAP_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [lkv_pkg::OP_BITS-1:0]  op_ff, op_in;
   logic [KEY_BITS-1:0]          key_ff, key_in;
   logic [VALUE_BITS-1:0]        value_ff, value_in;

   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         probe_vld_ff, probe_vld_in;
   logic [IW-1:0]                probe_idx_ff, probe_idx_in;
   logic                         valid_rd_ff;

   logic                         found_vld_ff, found_vld_in;
   logic [IW-1:0]                found_idx_ff, found_idx_in;
   logic [IW-1:0]                ref_rank_ff, ref_rank_in;
   logic                         victim_vld_ff, victim_vld_in;
   logic [IW-1:0]                victim_idx_ff, victim_idx_in;
   logic [IW-1:0]                victim_rank_ff, victim_rank_in;
   logic [KEY_BITS-1:0]          victim_key_ff, victim_key_in;
   logic                         free_vld_ff, free_vld_in;
   logic [IW-1:0]                free_idx_ff, free_idx_in;

   logic                         hit_ff, hit_in;
   logic                         evict_ff, evict_in;
   logic                         insert_ff, insert_in;
   logic [IW-1:0]                tgt_idx_ff, tgt_idx_in;

   logic [MAX_ENTRIES-1:0]       valid_ff, valid_in;
   logic [CW-1:0]                occ_ff, occ_in;
   logic [lkv_pkg::CAP_BITS-1:0] cap_ff, cap_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [VALUE_BITS-1:0]        rsp_rdata_ff, rsp_rdata_in;
   logic                         rsp_ev_ff, rsp_ev_in;
   logic [KEY_BITS-1:0]          rsp_evkey_ff, rsp_evkey_in;

   // RAM ports
   logic                         key_we, val_we, rank_we;
   logic [IW-1:0]                key_wa, val_wa, rank_wa;
   logic [VALUE_BITS-1:0]        val_wd;
   logic [IW-1:0]                rank_wd;
   logic [IW-1:0]                scan_addr;
   logic [KEY_BITS-1:0]          key_rd;
   logic [VALUE_BITS-1:0]        val_rd;
   logic [IW-1:0]                rank_rd;

   logic                         issue;
   logic [EW-1:0]                eff_cap;
   logic                         evict_now;
   logic                         insert_now;
   logic [IW-1:0]                slot;

   assign scan_addr = cnt_ff[IW-1:0];
   assign issue     = (cnt_ff < CW'(MAX_ENTRIES));

   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = EW'(1);
      end else if (EW'(cap_ff) > EW'(MAX_ENTRIES)) begin
         eff_cap = EW'(MAX_ENTRIES);
      end else begin
         eff_cap = EW'(cap_ff);
      end
   end

   // miss decisions, used in the decide step
   always_comb begin
      evict_now  = !found_vld_ff && (op_ff == lkv_pkg::OP_PUT) && victim_vld_ff &&
                   (EW'(occ_ff) >= eff_cap);
      if (evict_now) begin
         slot = (free_vld_ff && (free_idx_ff < victim_idx_ff)) ? free_idx_ff : victim_idx_ff;
      end else begin
         slot = free_idx_ff;
      end
      insert_now = !found_vld_ff && (op_ff == lkv_pkg::OP_PUT) && (evict_now || free_vld_ff);
   end

   lkv_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(KEY_BITS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_wa),
      .wr_data (key_ff),
      .rd_addr (scan_addr),
      .rd_data (key_rd)
   );

   lkv_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(VALUE_BITS)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (found_idx_ff),
      .rd_data (val_rd)
   );

   lkv_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(IW)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_wa),
      .wr_data (rank_wd),
      .rd_addr (scan_addr),
      .rd_data (rank_rd)
   );

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      cnt_in         = cnt_ff;
      probe_vld_in   = 1'b0;
      probe_idx_in   = probe_idx_ff;
      found_vld_in   = found_vld_ff;
      found_idx_in   = found_idx_ff;
      ref_rank_in    = ref_rank_ff;
      victim_vld_in  = victim_vld_ff;
      victim_idx_in  = victim_idx_ff;
      victim_rank_in = victim_rank_ff;
      victim_key_in  = victim_key_ff;
      free_vld_in    = free_vld_ff;
      free_idx_in    = free_idx_ff;
      hit_in         = hit_ff;
      evict_in       = evict_ff;
      insert_in      = insert_ff;
      tgt_idx_in     = tgt_idx_ff;
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      cap_in         = cap_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_rdata_in   = rsp_rdata_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_evkey_in   = rsp_evkey_ff;
      key_we         = 1'b0;
      key_wa         = slot;
      val_we         = 1'b0;
      val_wa         = slot;
      val_wd         = value_ff;
      rank_we        = 1'b0;
      rank_wa        = probe_idx_ff;
      rank_wd        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in         = req_bus.operation;
               key_in        = req_bus.key;
               value_in      = req_bus.value;
               cnt_in        = '0;
               found_vld_in  = 1'b0;
               victim_vld_in = 1'b0;
               free_vld_in   = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // one entry a cycle through the key compare and rank compare
            if (probe_vld_ff) begin
               if (valid_rd_ff && (key_rd == key_ff) && !found_vld_ff) begin
                  found_vld_in = 1'b1;
                  found_idx_in = probe_idx_ff;
                  ref_rank_in  = rank_rd;
               end
               if (valid_rd_ff && (!victim_vld_ff || (rank_rd > victim_rank_ff))) begin
                  victim_vld_in  = 1'b1;
                  victim_idx_in  = probe_idx_ff;
                  victim_rank_in = rank_rd;
                  victim_key_in  = key_rd;
               end
               if (!valid_rd_ff && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = probe_idx_ff;
               end
            end
            if (issue) begin
               cnt_in       = cnt_ff + CW'(1);
               probe_vld_in = 1'b1;
               probe_idx_in = scan_addr;
            end else begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            hit_in    = found_vld_ff;
            evict_in  = evict_now;
            insert_in = insert_now;
            cnt_in    = '0;
            if (found_vld_ff) begin
               tgt_idx_in = found_idx_ff;
               if (op_ff == lkv_pkg::OP_PUT) begin
                  val_we = 1'b1;
                  val_wa = found_idx_ff;
               end
            end else if (insert_now) begin
               tgt_idx_in = slot;
               key_we     = 1'b1;
               val_we     = 1'b1;
               if (evict_now) begin
                  valid_in[victim_idx_ff] = 1'b0;
               end else begin
                  occ_in = occ_ff + CW'(1);
               end
               valid_in[slot] = 1'b1;
            end
            state_in = (found_vld_ff || insert_now) ? ST_UPDATE : ST_DONE;
         end

         ST_UPDATE: begin
            // insert ages every valid entry; a hit ages only the younger ones
            if (probe_vld_ff) begin
               rank_we = 1'b1;
               if (probe_idx_ff == tgt_idx_ff) begin
                  rank_wd = '0;
               end else if (valid_rd_ff && (insert_ff || (rank_rd < ref_rank_ff))) begin
                  rank_wd = rank_rd + IW'(1);
               end else begin
                  rank_wd = rank_rd;
               end
            end
            if (issue) begin
               cnt_in       = cnt_ff + CW'(1);
               probe_vld_in = 1'b1;
               probe_idx_in = scan_addr;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_rdata_in = (hit_ff && (op_ff == lkv_pkg::OP_GET)) ? val_rd : '0;
               rsp_ev_in    = evict_ff;
               rsp_evkey_in = evict_ff ? victim_key_ff : '0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         cap_in   = csr_wdata;
         valid_in = '0;
         occ_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         probe_vld_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= lkv_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_vld_ff <= probe_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      cnt_ff         <= cnt_in;
      probe_idx_ff   <= probe_idx_in;
      valid_rd_ff    <= valid_ff[scan_addr];
      found_vld_ff   <= found_vld_in;
      found_idx_ff   <= found_idx_in;
      ref_rank_ff    <= ref_rank_in;
      victim_vld_ff  <= victim_vld_in;
      victim_idx_ff  <= victim_idx_in;
      victim_rank_ff <= victim_rank_in;
      victim_key_ff  <= victim_key_in;
      free_vld_ff    <= free_vld_in;
      free_idx_ff    <= free_idx_in;
      hit_ff         <= hit_in;
      evict_ff       <= evict_in;
      insert_ff      <= insert_in;
      tgt_idx_ff     <= tgt_idx_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_rdata_ff   <= rsp_rdata_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.read_value  = rsp_rdata_ff;
   assign rsp_bus.evicted     = rsp_ev_ff;
   assign rsp_bus.evicted_key = rsp_evkey_ff;

endmodule

### design/lkv_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lru_key_value_cache_top_defines.svh and the top level's ports.
`include "lru_key_value_cache_top_defines.svh"

module lkv_checker #(
   parameter int KEY_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic [VALUE_BITS-1:0] rsp_read_value,
   input logic                  rsp_evicted,
   input logic [KEY_BITS-1:0]   rsp_evicted_key
);

   // an accepted item keeps the block busy, so ready drops after an accept
   `LKV_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "accepted twice in a row")

   `LKV_ASSERT_NOW(a_evict_only_on_miss, rsp_valid && rsp_evicted, !rsp_hit, "eviction on a hit")

   `LKV_ASSERT_NOW(a_miss_reads_zero, rsp_valid && !rsp_hit, rsp_read_value == '0, "miss with data")

   `LKV_ASSERT_NOW(a_no_evict_key_zero, rsp_valid && !rsp_evicted, rsp_evicted_key == '0, "stray evicted key")

   `LKV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_evicted_key), "stalled item changed")

endmodule

bind lru_key_value_cache_top lkv_checker #(
   .KEY_BITS   (KEY_BITS),
   .VALUE_BITS (VALUE_BITS)
) u_lkv_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_hit         (rsp_bus.hit),
   .rsp_read_value  (rsp_bus.read_value),
   .rsp_evicted     (rsp_bus.evicted),
   .rsp_evicted_key (rsp_bus.evicted_key)
);
